FILE: rtl/utf8e_pkg.sv
// Shared constants and types of the bounded UTF-8 character encoder.
package utf8e_pkg;

    localparam int CpW      = 31;
    localparam int ByteW    = 8;
    localparam int MaxBytes = 6;
    localparam int CntW     = 3;
    localparam int CapW     = 17;
    localparam int AddrW    = 3;
    localparam int DataW    = 32;

    // Register index taken from paddr[2]
    localparam logic [0:0] RegCapacity = 1'b0;
    localparam logic [CapW-1:0] CapReset = 17'd256;

    // Range limits of the byte-count classes
    localparam logic [CpW-1:0] Lim1 = 31'h80;
    localparam logic [CpW-1:0] Lim2 = 31'h800;
    localparam logic [CpW-1:0] Lim3 = 31'h10000;
    localparam logic [CpW-1:0] Lim4 = 31'h200000;
    localparam logic [CpW-1:0] Lim5 = 31'h4000000;

    // Lead-byte marks and continuation mark
    localparam logic [ByteW-1:0] LeadMark2 = 8'hC0;
    localparam logic [ByteW-1:0] LeadMark3 = 8'hE0;
    localparam logic [ByteW-1:0] LeadMark4 = 8'hF0;
    localparam logic [ByteW-1:0] LeadMark5 = 8'hF8;
    localparam logic [ByteW-1:0] LeadMark6 = 8'hFC;
    localparam logic [ByteW-1:0] ContMark  = 8'h80;

    // Byte counts
    localparam logic [CntW-1:0] Cnt1 = 3'd1;
    localparam logic [CntW-1:0] Cnt2 = 3'd2;
    localparam logic [CntW-1:0] Cnt3 = 3'd3;
    localparam logic [CntW-1:0] Cnt4 = 3'd4;
    localparam logic [CntW-1:0] Cnt5 = 3'd5;
    localparam logic [CntW-1:0] Cnt6 = 3'd6;

    // One encoded character: bytes in send order from index 0
    typedef struct packed {
        logic [MaxBytes-1:0][ByteW-1:0] bytes;
        logic [CntW-1:0]                count;
        logic                           dropped;
    } beat_t;

endpackage

FILE: rtl/utf8e_encode.sv
// Byte-count classing, fit test and UTF-8 byte building for one code point.
module utf8e_encode (
    input  logic [utf8e_pkg::CpW-1:0]  code_point,
    input  logic [utf8e_pkg::CapW-1:0] bytes_used,
    input  logic [utf8e_pkg::CapW-1:0] capacity,
    output utf8e_pkg::beat_t           beat,
    output logic [utf8e_pkg::CapW-1:0] used_next
);
    import utf8e_pkg::*;

    logic [CntW-1:0]                n;
    logic [CapW:0]                  total;
    logic                           drop;
    logic [MaxBytes-1:0][ByteW-1:0] enc;

    // Class the code point by its byte count; zero takes the two-byte form
    always_comb
    begin
        if (code_point == '0)
            n = Cnt2;
        else if (code_point < Lim1)
            n = Cnt1;
        else if (code_point < Lim2)
            n = Cnt2;
        else if (code_point < Lim3)
            n = Cnt3;
        else if (code_point < Lim4)
            n = Cnt4;
        else if (code_point < Lim5)
            n = Cnt5;
        else
            n = Cnt6;
    end

    // Drop when the bytes plus the terminator slot would overrun capacity
    assign total = {1'b0, bytes_used} + {{(CapW+1-CntW){1'b0}}, n} + (CapW+1)'(1);
    assign drop  = total > {1'b0, capacity};

    // Build the bytes, most significant first
    always_comb
    begin
        enc = '0;
        case (n)
            Cnt1:
            begin
                enc[0] = {1'b0, code_point[6:0]};
            end
            Cnt2:
            begin
                enc[0] = LeadMark2 | {3'b0, code_point[10:6]};
                enc[1] = ContMark | {2'b0, code_point[5:0]};
            end
            Cnt3:
            begin
                enc[0] = LeadMark3 | {4'b0, code_point[15:12]};
                enc[1] = ContMark | {2'b0, code_point[11:6]};
                enc[2] = ContMark | {2'b0, code_point[5:0]};
            end
            Cnt4:
            begin
                enc[0] = LeadMark4 | {5'b0, code_point[20:18]};
                enc[1] = ContMark | {2'b0, code_point[17:12]};
                enc[2] = ContMark | {2'b0, code_point[11:6]};
                enc[3] = ContMark | {2'b0, code_point[5:0]};
            end
            Cnt5:
            begin
                enc[0] = LeadMark5 | {6'b0, code_point[25:24]};
                enc[1] = ContMark | {2'b0, code_point[23:18]};
                enc[2] = ContMark | {2'b0, code_point[17:12]};
                enc[3] = ContMark | {2'b0, code_point[11:6]};
                enc[4] = ContMark | {2'b0, code_point[5:0]};
            end
            default:
            begin
                enc[0] = LeadMark6 | {7'b0, code_point[30]};
                enc[1] = ContMark | {2'b0, code_point[29:24]};
                enc[2] = ContMark | {2'b0, code_point[23:18]};
                enc[3] = ContMark | {2'b0, code_point[17:12]};
                enc[4] = ContMark | {2'b0, code_point[11:6]};
                enc[5] = ContMark | {2'b0, code_point[5:0]};
            end
        endcase
    end

    // A dropped character becomes a single zero byte with the flag set
    always_comb
    begin
        if (drop)
        begin
            beat.bytes   = '0;
            beat.count   = Cnt1;
            beat.dropped = 1'b1;
            used_next    = bytes_used;
        end
        else
        begin
            beat.bytes   = enc;
            beat.count   = n;
            beat.dropped = 1'b0;
            used_next    = bytes_used + {{(CapW-CntW){1'b0}}, n};
        end
    end

endmodule

FILE: rtl/utf8e_emit.sv
// Output register that sends the bytes of one encoded character, one per transaction.
module utf8e_emit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  utf8e_pkg::beat_t            beat,
    output logic                        ready,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [utf8e_pkg::ByteW-1:0] m_axis_tdata,  // out_byte[7:0]
    output logic                        m_axis_tlast,
    output logic                        m_axis_tuser   // dropped
);
    import utf8e_pkg::*;

    logic [MaxBytes-1:0][ByteW-1:0] bytes_reg;
    logic [MaxBytes-1:0][ByteW-1:0] bytes_next;
    logic [CntW-1:0]                cnt_reg;
    logic [CntW-1:0]                cnt_next;
    logic                           dropped_reg;
    logic                           dropped_next;
    logic                           take;

    assign take  = m_axis_tvalid && m_axis_tready;
    // Free for a new character when empty or when the final byte leaves now
    assign ready = (cnt_reg == '0) || ((cnt_reg == Cnt1) && m_axis_tready);

    // Load a new character, or advance to the next byte on each transaction
    always_comb
    begin
        bytes_next   = bytes_reg;
        cnt_next     = cnt_reg;
        dropped_next = dropped_reg;
        if (load)
        begin
            bytes_next   = beat.bytes;
            cnt_next     = beat.count;
            dropped_next = beat.dropped;
        end
        else if (take)
        begin
            bytes_next = bytes_reg >> ByteW;
            cnt_next   = cnt_reg - Cnt1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            dropped_reg <= dropped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

    assign m_axis_tvalid = cnt_reg != '0;
    assign m_axis_tdata  = bytes_reg[0];
    assign m_axis_tlast  = cnt_reg == Cnt1;
    assign m_axis_tuser  = dropped_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= Cnt6)
        else $error("byte count above six");

    a_drop_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == '0))
        else $error("dropped result is not a single zero byte");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("character run cut short");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (m_axis_tvalid && cnt_reg == $past(beat.count)))
        else $error("loaded character not presented");

endmodule

FILE: rtl/utf8_char_encoder_bounded_core.sv
// Top level of the bounded UTF-8 character encoder: input stage, registers and byte count.
//
// Usage:
//   s_axis carries one code point per transaction in tdata[30:0]. m_axis
//   returns the UTF-8 bytes of each character, lead byte first, one byte per
//   transaction in tdata[7:0]; tlast marks the final byte of a character and
//   tuser marks a dropped character (a single zero byte with tlast set).
//   Code point zero is sent as C0 80. A running byte count is kept against
//   the capacity register (APB, byte address 0, reset 256), which reserves
//   one terminator slot; a character that would not fit is dropped and the
//   count stays put. Write capacity only while the block is idle.
// Timing:
//   A code point passes the input register, then the output register, before
//   its first byte. An n-byte character holds the single output register for
//   n transactions: one-byte characters go at one per cycle while the receiver
//   does not stall, others at one per n transactions, set by the byte-wide port.
// Reset and stall:
//   Reset clears the byte count, sets capacity to 256 and empties both
//   stages. When the receiver stalls, the output holds its byte and the
//   input register holds one pending code point before tready drops.
module utf8_char_encoder_bounded_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [utf8e_pkg::DataW-1:0] s_axis_tdata,  // code_point[30:0], zero[31]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [utf8e_pkg::ByteW-1:0] m_axis_tdata,  // out_byte[7:0]
    output logic                        m_axis_tlast,
    output logic                        m_axis_tuser,  // dropped
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [utf8e_pkg::AddrW-1:0] paddr,
    input  logic [utf8e_pkg::DataW-1:0] pwdata,
    output logic [utf8e_pkg::DataW-1:0] prdata,
    output logic                        pready
);
    import utf8e_pkg::*;

    logic [CpW-1:0]  cp_reg;
    logic [CpW-1:0]  cp_next;
    logic            in_valid_reg;
    logic            in_valid_next;
    logic [CapW-1:0] capacity_reg;
    logic [CapW-1:0] capacity_next;
    logic [CapW-1:0] used_reg;
    logic [CapW-1:0] used_next;
    logic [CapW-1:0] used_enc;
    logic            emit_ready;
    logic            load;
    logic            in_take;
    logic            cfg_write;
    beat_t           beat;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == RegCapacity);
    assign prdata    = (paddr[2] == RegCapacity) ? {{(DataW-CapW){1'b0}}, capacity_reg} : '0;
    assign capacity_next = cfg_write ? pwdata[CapW-1:0] : capacity_reg;

    // Input stage: hold one code point until the output side takes it
    assign load          = in_valid_reg && emit_ready;
    assign s_axis_tready = !in_valid_reg || emit_ready;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        cp_next       = cp_reg;
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            cp_next       = s_axis_tdata[CpW-1:0];
            in_valid_next = 1'b1;
        end
        else if (load)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Advance the byte count when a character is handed to the output
    assign used_next = load ? used_enc : used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            capacity_reg <= CapReset;
            used_reg     <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            capacity_reg <= capacity_next;
            used_reg     <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg <= cp_next;
    end

    utf8e_encode u_encode (
        .code_point (cp_reg),
        .bytes_used (used_reg),
        .capacity   (capacity_reg),
        .beat       (beat),
        .used_next  (used_enc)
    );

    utf8e_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .beat          (beat),
        .ready         (emit_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
